[src/assert_macros.svh]
// Assertion macros used by the checker of the message buffer queue manager.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MBQ_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define MBQ_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[src/mbq_pkg.sv]
// Shared types, constants and helper functions of the message buffer queue manager.
// No dependencies; imported by every module of the block.
package mbq_pkg;

  // Pool and task sizes.
  localparam int NUM_BUFFERS = 16;
  localparam int NUM_TASKS   = 16;

  // Widths: a buffer index, a link that also holds the none marker, fixed fields.
  localparam int IDX_W     = $clog2(NUM_BUFFERS);
  localparam int LINK_W    = $clog2(NUM_BUFFERS + 1);
  localparam int TASK_W    = 4;
  localparam int OP_W      = 2;
  localparam int BUF_W     = 8;
  localparam int SVC_W     = 8;
  localparam int STATUS_W  = 3;
  localparam int BIDX_W    = 4;

  // Configuration port.
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 64;
  localparam logic REG_ROUTE_TABLE = 1'b0;

  // Marker for the end of a list or an empty queue.
  localparam logic [LINK_W-1:0] LINK_NONE = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_POST    = 2'd2,
    OP_GET     = 2'd3
  } mbq_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_FREE    = 3'd1,
    ST_BAD_BUFFER = 3'd2,
    ST_NOT_ALLOC  = 3'd3,
    ST_UNROUTED   = 3'd4,
    ST_BAD_TASK   = 3'd5,
    ST_EMPTY      = 3'd6
  } mbq_status_t;

  // Write command to the link store.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [LINK_W-1:0] data;
  } mbq_link_wr_t;

  // Write command to the queue head store.
  typedef struct packed {
    logic              en;
    logic [TASK_W-1:0] addr;
    logic [LINK_W-1:0] data;
  } mbq_head_wr_t;

  // A link names a real buffer only below the pool size.
  function automatic logic is_idx(input logic [LINK_W-1:0] v);
    return 32'(v) < NUM_BUFFERS;
  endfunction

  function automatic logic [IDX_W-1:0] to_idx(input logic [LINK_W-1:0] v);
    return v[IDX_W-1:0];
  endfunction

  // Task number routed for a service code, taken from its high nibble.
  function automatic logic [TASK_W-1:0] route_of(input logic [DATA_W-1:0] table_v,
                                                 input logic [SVC_W-1:0] svc);
    logic [5:0] base;
    base = {svc[7:4], 2'b00};
    return table_v[base +: TASK_W];
  endfunction

endpackage

[src/message_buffer_queue_manager_top.sv]
// Top level of the message buffer queue manager: register port, sequencer and stores.
// Depends on mbq_pkg, mbq_store and mbq_seq.
//
//  Channel  Direction  Handshake              Beat contents
//  in       input      in_valid / in_stall    op, buffer, service, task_req
//  out      output     out_valid / out_stall  status, buffer_index
//  config   input      APB psel/penable       route_table at byte address 0
//
// Allocate passes the dispatch, free-list read and done states; get the dispatch, head read,
// link read and done states. Release and post both walk a list through the link store,
// one link read per cycle.
// Reset is synchronous; the stores need no clearing pass, so an item may be offered at once.
// A stalled result stays in the output register while the next item is accepted.
module message_buffer_queue_manager_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbq_pkg::ADDR_W-1:0]    paddr,
  input  logic [mbq_pkg::DATA_W-1:0]    pwdata,
  output logic [mbq_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mbq_pkg::OP_W-1:0]      op,
  input  logic [mbq_pkg::BUF_W-1:0]     buffer,
  input  logic [mbq_pkg::SVC_W-1:0]     service,
  input  logic [mbq_pkg::TASK_W-1:0]    task_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mbq_pkg::STATUS_W-1:0]  status,
  output logic [mbq_pkg::BIDX_W-1:0]    buffer_index
);
  import mbq_pkg::*;

  logic [DATA_W-1:0] route_table;
  logic              reg_sel;
  logic              cfg_write;
  logic [IDX_W-1:0]  link_raddr;
  logic [LINK_W-1:0] link_rdata;
  mbq_link_wr_t      link_wr;
  logic [TASK_W-1:0] head_raddr;
  logic [LINK_W-1:0] head_rdata;
  mbq_head_wr_t      head_wr;

  // Register decode: paddr[3] picks an 8-byte slot; only slot 0 holds a 64-bit register.
  assign reg_sel   = paddr[3];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (reg_sel == REG_ROUTE_TABLE) ? route_table : '0;

  // Route table register.
  always_ff @(posedge clk) begin
    if (rst) begin
      route_table <= '0;
    end else if (cfg_write && reg_sel == REG_ROUTE_TABLE) begin
      route_table <= pwdata;
    end
  end

  mbq_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .route_table  (route_table),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .buffer       (buffer),
    .service      (service),
    .task_req     (task_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .buffer_index (buffer_index),
    .link_raddr   (link_raddr),
    .link_rdata   (link_rdata),
    .link_wr      (link_wr),
    .head_raddr   (head_raddr),
    .head_rdata   (head_rdata),
    .head_wr      (head_wr)
  );

  mbq_store u_store (
    .clk        (clk),
    .rst        (rst),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata),
    .link_wr    (link_wr),
    .head_raddr (head_raddr),
    .head_rdata (head_rdata),
    .head_wr    (head_wr)
  );

endmodule

[src/mbq_store.sv]
// Link store and queue head store, each one read and one write port, registered reads.
// Depends on mbq_pkg. Per-entry valid bits give the reset contents without a clearing pass.
module mbq_store (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [mbq_pkg::IDX_W-1:0]    link_raddr,
  output logic [mbq_pkg::LINK_W-1:0]   link_rdata,
  input  mbq_pkg::mbq_link_wr_t        link_wr,
  input  logic [mbq_pkg::TASK_W-1:0]   head_raddr,
  output logic [mbq_pkg::LINK_W-1:0]   head_rdata,
  input  mbq_pkg::mbq_head_wr_t        head_wr
);
  import mbq_pkg::*;

  logic [LINK_W-1:0] link_mem [NUM_BUFFERS];
  logic [LINK_W-1:0] head_mem [NUM_TASKS];
  logic [NUM_BUFFERS-1:0] link_vld;
  logic [NUM_TASKS-1:0]   head_vld;

  logic [LINK_W-1:0] link_q;
  logic [LINK_W-1:0] head_q;
  logic              link_vq;
  logic              head_vq;
  logic [IDX_W-1:0]  link_raddr_q;
  logic [LINK_W-1:0] link_init;

  // Memory arrays: write and registered read.
  always_ff @(posedge clk) begin
    if (link_wr.en) begin
      link_mem[link_wr.addr] <= link_wr.data;
    end
    if (head_wr.en) begin
      head_mem[head_wr.addr] <= head_wr.data;
    end
    link_q       <= link_mem[link_raddr];
    head_q       <= head_mem[head_raddr];
    link_raddr_q <= link_raddr;
  end

  // Valid bits mark entries written since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
      head_vld <= '0;
      link_vq  <= 1'b0;
      head_vq  <= 1'b0;
    end else begin
      if (link_wr.en) begin
        link_vld[link_wr.addr] <= 1'b1;
      end
      if (head_wr.en) begin
        head_vld[head_wr.addr] <= 1'b1;
      end
      link_vq <= link_vld[link_raddr];
      head_vq <= head_vld[head_raddr];
    end
  end

  // Reset contents: each buffer links to the next, the last to none.
  always_comb begin
    if (32'(link_raddr_q) == NUM_BUFFERS - 1) begin
      link_init = LINK_NONE;
    end else begin
      link_init = LINK_W'(32'(link_raddr_q) + 1);
    end
  end

  assign link_rdata = link_vq ? link_q : link_init;
  assign head_rdata = head_vq ? head_q : LINK_NONE;

endmodule

[src/mbq_seq.sv]
// Operation sequencer: decodes one item, walks the lists one link per cycle, holds the result.
// Depends on mbq_pkg; drives the stores in mbq_store.
module mbq_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mbq_pkg::DATA_W-1:0]    route_table,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mbq_pkg::OP_W-1:0]      op,
  input  logic [mbq_pkg::BUF_W-1:0]     buffer,
  input  logic [mbq_pkg::SVC_W-1:0]     service,
  input  logic [mbq_pkg::TASK_W-1:0]    task_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mbq_pkg::STATUS_W-1:0]  status,
  output logic [mbq_pkg::BIDX_W-1:0]    buffer_index,
  output logic [mbq_pkg::IDX_W-1:0]     link_raddr,
  input  logic [mbq_pkg::LINK_W-1:0]    link_rdata,
  output mbq_pkg::mbq_link_wr_t         link_wr,
  output logic [mbq_pkg::TASK_W-1:0]    head_raddr,
  input  logic [mbq_pkg::LINK_W-1:0]    head_rdata,
  output mbq_pkg::mbq_head_wr_t         head_wr
);
  import mbq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ALLOC_RD,
    S_REL_WALK,
    S_POST_HEAD,
    S_POST_WALK,
    S_GET_HEAD,
    S_GET_LINK,
    S_DONE
  } state_t;

  state_t            state;
  mbq_op_t           op_q;
  logic [IDX_W-1:0]  buf_q;
  logic              buf_ok;
  logic [TASK_W-1:0] route_q;
  logic [TASK_W-1:0] task_q;
  logic [LINK_W-1:0] p;
  logic [IDX_W-1:0]  steps;
  logic              first;
  logic [LINK_W-1:0] free_head;
  mbq_status_t       res_status;
  logic [IDX_W-1:0]  res_index;

  logic              accept;
  logic              out_free;
  logic              route_ok;
  logic              task_ok;
  logic              last_step;
  logic [LINK_W-1:0] cur;
  logic [LINK_W-1:0] buf_link;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign route_ok  = (route_q != '0) && (32'(route_q) < NUM_TASKS);
  assign task_ok   = (task_q != '0) && (32'(task_q) < NUM_TASKS);
  assign last_step = (32'(steps) == NUM_BUFFERS - 1);
  assign buf_link  = LINK_W'(buf_q);
  // The free-list walk looks at the held head first, then at each link read back.
  assign cur       = first ? p : link_rdata;

  // Store addresses and write commands for the current step.
  always_comb begin
    link_raddr = '0;
    head_raddr = '0;
    link_wr    = '0;
    head_wr    = '0;
    case (state)
      S_DISPATCH: begin
        case (op_q)
          OP_ALLOC: begin
            link_raddr = to_idx(free_head);
          end
          OP_POST: begin
            head_raddr = route_q;
          end
          OP_GET: begin
            head_raddr = task_q;
          end
          default: begin
          end
        endcase
      end
      S_ALLOC_RD: begin
        link_wr = '{en: 1'b1, addr: to_idx(p), data: LINK_NONE};
      end
      S_REL_WALK: begin
        if (!is_idx(cur) || (cur != buf_link && last_step)) begin
          link_wr = '{en: 1'b1, addr: buf_q, data: free_head};
        end else if (cur != buf_link) begin
          link_raddr = to_idx(cur);
        end
      end
      S_POST_HEAD: begin
        if (!is_idx(head_rdata)) begin
          head_wr = '{en: 1'b1, addr: route_q, data: buf_link};
        end else begin
          link_raddr = to_idx(head_rdata);
        end
      end
      S_POST_WALK: begin
        if (!is_idx(link_rdata)) begin
          link_wr = '{en: 1'b1, addr: to_idx(p), data: buf_link};
        end else if (last_step) begin
          link_wr = '{en: 1'b1, addr: to_idx(link_rdata), data: buf_link};
        end else begin
          link_raddr = to_idx(link_rdata);
        end
      end
      S_GET_HEAD: begin
        link_raddr = to_idx(head_rdata);
      end
      S_GET_LINK: begin
        if (is_idx(link_rdata)) begin
          head_wr = '{en: 1'b1, addr: task_q, data: link_rdata};
          link_wr = '{en: 1'b1, addr: to_idx(p), data: LINK_NONE};
        end else begin
          head_wr = '{en: 1'b1, addr: task_q, data: LINK_NONE};
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer state, working registers, free head and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result empties the output register; the done step refills it on its own.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_q       <= mbq_op_t'(op);
            buf_q      <= IDX_W'(buffer);
            buf_ok     <= 32'(buffer) < NUM_BUFFERS;
            route_q    <= route_of(route_table, service);
            task_q     <= task_req;
            res_status <= ST_OK;
            res_index  <= '0;
            state      <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (op_q)
            OP_ALLOC: begin
              if (!is_idx(free_head)) begin
                res_status <= ST_NO_FREE;
                state      <= S_DONE;
              end else begin
                p     <= free_head;
                state <= S_ALLOC_RD;
              end
            end
            OP_RELEASE: begin
              if (!buf_ok) begin
                res_status <= ST_BAD_BUFFER;
                state      <= S_DONE;
              end else begin
                p     <= free_head;
                first <= 1'b1;
                steps <= '0;
                state <= S_REL_WALK;
              end
            end
            OP_POST: begin
              if (!buf_ok) begin
                res_status <= ST_BAD_BUFFER;
                state      <= S_DONE;
              end else if (!route_ok) begin
                res_status <= ST_UNROUTED;
                state      <= S_DONE;
              end else begin
                state <= S_POST_HEAD;
              end
            end
            default: begin
              if (!task_ok) begin
                res_status <= ST_BAD_TASK;
                state      <= S_DONE;
              end else begin
                state <= S_GET_HEAD;
              end
            end
          endcase
        end
        S_ALLOC_RD: begin
          free_head <= link_rdata;
          res_index <= to_idx(p);
          state     <= S_DONE;
        end
        S_REL_WALK: begin
          // Push onto the free list at the end of the walk unless the buffer was found.
          if (!is_idx(cur) || (cur != buf_link && last_step)) begin
            free_head <= buf_link;
            state     <= S_DONE;
          end else if (cur == buf_link) begin
            res_status <= ST_NOT_ALLOC;
            state      <= S_DONE;
          end else begin
            first <= 1'b0;
            steps <= steps + 1'b1;
          end
        end
        S_POST_HEAD: begin
          if (!is_idx(head_rdata)) begin
            state <= S_DONE;
          end else begin
            p     <= head_rdata;
            steps <= '0;
            state <= S_POST_WALK;
          end
        end
        S_POST_WALK: begin
          if (!is_idx(link_rdata) || last_step) begin
            state <= S_DONE;
          end else begin
            p     <= link_rdata;
            steps <= steps + 1'b1;
          end
        end
        S_GET_HEAD: begin
          if (!is_idx(head_rdata)) begin
            res_status <= ST_EMPTY;
            state      <= S_DONE;
          end else begin
            p     <= head_rdata;
            state <= S_GET_LINK;
          end
        end
        S_GET_LINK: begin
          res_index <= to_idx(p);
          state     <= S_DONE;
        end
        S_DONE: begin
          // Hand the result to the output register once it is free.
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            buffer_index <= BIDX_W'(res_index);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/mbq_checker.sv]
// Port-level checks of the message buffer queue manager, bound to its top level.
// Depends on mbq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [mbq_pkg::STATUS_W-1:0]  status,
  input logic [mbq_pkg::BIDX_W-1:0]    buffer_index
);
  import mbq_pkg::*;

  // An accepted beat keeps the block busy for at least the next cycle.
  `MBQ_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // A stalled result holds its value.
  `MBQ_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(buffer_index))

  // Failed operations report buffer index zero.
  `MBQ_ASSERT_IMP(a_err_index_zero, clk, rst, out_valid && status != ST_OK, buffer_index == '0)

  // A new result only appears after the block has been busy with an item.
  `MBQ_ASSERT_IMP(a_result_after_work, clk, rst, $rose(out_valid), $past(in_stall))

endmodule

bind message_buffer_queue_manager_top mbq_checker u_mbq_checker (.*);

[tb/sv/tb_message_buffer_queue_manager_top.sv]
// Self-checking testbench for the message buffer queue manager top level.
// Depends on mbq_pkg and message_buffer_queue_manager_top; a scoreboard class predicts each result.
module tb_message_buffer_queue_manager_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int IDLE_TAIL      = NUM_BUFFERS + 8;
  localparam logic [ADDR_W-1:0] ROUTE_ADDR = ADDR_W'(8 * int'(REG_ROUTE_TABLE));

  // One predicted result beat.
  typedef struct packed {
    mbq_status_t       status;
    logic [BIDX_W-1:0] index;
  } outcome_t;

  // Pool predictor with its own copy of the links, heads and route table.
  class pool_scoreboard;
    logic [DATA_W-1:0] route_table;
    logic [LINK_W-1:0] free_head;
    logic [LINK_W-1:0] queue_head [NUM_TASKS];
    logic [LINK_W-1:0] next_link [NUM_BUFFERS];
    outcome_t          awaited_results [$];
    int                errors;

    function new();
      route_table = '0;
      free_head   = '0;
      errors      = 0;
      foreach (queue_head[i]) queue_head[i] = LINK_NONE;
      foreach (next_link[i]) next_link[i] = LINK_W'(i + 1);
      next_link[NUM_BUFFERS-1] = LINK_NONE;
    endfunction

    function bit names_buffer(logic [LINK_W-1:0] v);
      return int'(v) < NUM_BUFFERS;
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function outcome_t note_request(mbq_op_t code, logic [BUF_W-1:0] buf_in,
                                    logic [SVC_W-1:0] svc, logic [TASK_W-1:0] task_in);
      outcome_t          res;
      logic [LINK_W-1:0] p;
      logic [LINK_W-1:0] n;
      logic [TASK_W-1:0] q;
      res.status = ST_OK;
      res.index  = '0;
      case (code)
        OP_ALLOC: begin
          p = free_head;
          if (!names_buffer(p)) begin
            res.status = ST_NO_FREE;
          end else begin
            free_head = next_link[p[IDX_W-1:0]];
            next_link[p[IDX_W-1:0]] = LINK_NONE;
            res.index = p[BIDX_W-1:0];
          end
        end
        OP_RELEASE: begin
          if (int'(buf_in) >= NUM_BUFFERS) begin
            res.status = ST_BAD_BUFFER;
          end else begin
            // Double-free check: a bounded walk of the free list.
            p = free_head;
            for (int steps = 0; steps < NUM_BUFFERS && names_buffer(p); steps++) begin
              if (int'(p) == int'(buf_in)) begin
                res.status = ST_NOT_ALLOC;
                break;
              end
              p = next_link[p[IDX_W-1:0]];
            end
            if (res.status == ST_OK) begin
              next_link[buf_in[IDX_W-1:0]] = free_head;
              free_head = LINK_W'(buf_in);
            end
          end
        end
        OP_POST: begin
          q = route_table[int'(svc[7:4]) * 4 +: TASK_W];
          if (int'(buf_in) >= NUM_BUFFERS) begin
            res.status = ST_BAD_BUFFER;
          end else if (q == '0 || int'(q) >= NUM_TASKS) begin
            res.status = ST_UNROUTED;
          end else begin
            p = queue_head[q];
            if (!names_buffer(p)) begin
              queue_head[q] = LINK_W'(buf_in);
            end else begin
              // Tail walk, cut short after one link per buffer.
              for (int steps = 0; steps < NUM_BUFFERS; steps++) begin
                n = next_link[p[IDX_W-1:0]];
                if (!names_buffer(n)) break;
                p = n;
              end
              next_link[p[IDX_W-1:0]] = LINK_W'(buf_in);
            end
          end
        end
        default: begin
          if (task_in == '0 || int'(task_in) >= NUM_TASKS) begin
            res.status = ST_BAD_TASK;
          end else begin
            p = queue_head[task_in];
            if (!names_buffer(p)) begin
              res.status = ST_EMPTY;
            end else begin
              n = next_link[p[IDX_W-1:0]];
              if (names_buffer(n)) begin
                queue_head[task_in] = n;
                next_link[p[IDX_W-1:0]] = LINK_NONE;
              end else begin
                queue_head[task_in] = LINK_NONE;
              end
              res.index = p[BIDX_W-1:0];
            end
          end
        end
      endcase
      awaited_results.push_back(res);
      return res;
    endfunction

    // Compare one result beat with the oldest prediction.
    function void check_result(logic [STATUS_W-1:0] st, logic [BIDX_W-1:0] idx);
      outcome_t want;
      if (awaited_results.size() == 0) begin
        $error("unexpected result beat: status %0d buffer_index %0d", st, idx);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (st !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, st);
        errors++;
      end
      if (idx !== want.index) begin
        $error("buffer_index mismatch: expected %0d, actual %0d", want.index, idx);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      op;
  logic [BUF_W-1:0]     buffer;
  logic [SVC_W-1:0]     service;
  logic [TASK_W-1:0]    task_req;
  logic                 out_valid;
  logic                 out_stall;
  logic [STATUS_W-1:0]  status;
  logic [BIDX_W-1:0]    buffer_index;

  pool_scoreboard       sb;
  int                   send_idle_pct;
  int                   recv_stall_pct;
  logic [BIDX_W-1:0]    held_buffers [$];

  message_buffer_queue_manager_top dut (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Buffers the stimulus currently owns, kept for well-formed sequences.
  function automatic void drop_held(logic [BIDX_W-1:0] b);
    for (int k = held_buffers.size() - 1; k >= 0; k--) begin
      if (held_buffers[k] == b) held_buffers.delete(k);
    end
  endfunction

  function automatic logic [DATA_W-1:0] random_route_table();
    logic [DATA_W-1:0] v;
    for (int n = 0; n < 16; n++) begin
      v[4*n +: 4] = ($urandom_range(3) == 0) ? 4'h0 : 4'($urandom_range(15, 1));
    end
    return v;
  endfunction

  // Offer one request beat after a random gap and note it once accepted.
  task automatic issue(input mbq_op_t code, input logic [BUF_W-1:0] b,
                       input logic [SVC_W-1:0] s, input logic [TASK_W-1:0] t);
    outcome_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    buffer   <= b;
    service  <= s;
    task_req <= t;
    do @(posedge clk); while (in_stall);
    res = sb.note_request(code, b, s, t);
    if (res.status == ST_OK) begin
      case (code)
        OP_ALLOC, OP_GET: begin
          drop_held(res.index);
          held_buffers.push_back(res.index);
        end
        default: drop_held(b[BIDX_W-1:0]);
      endcase
    end
  endtask

  // Hold the request side off until every predicted result has arrived.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.awaited_results.size() != 0);
  endtask

  // Register write followed by a read back, with the block idle.
  task automatic reconfigure(input logic [DATA_W-1:0] value);
    pause_until_drained();
    repeat (IDLE_TAIL) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROUTE_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.route_table = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $error("route_table read mismatch: expected %h, actual %h", value, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random phase: mostly well-formed alloc/post/get/release, some noise.
  task automatic run_phase(input int idle_pct, input int stall_pct,
                           input logic [DATA_W-1:0] route_v, input int alloc_pct,
                           input int count);
    int               r;
    int               k;
    int               nib;
    logic [SVC_W-1:0] s;
    logic [TASK_W-1:0] t;
    reconfigure(route_v);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) pause_until_drained();
      r   = $urandom_range(99);
      s   = SVC_W'($urandom);
      nib = $urandom_range(15);
      t   = route_v[4*nib +: 4];
      if (t == '0) t = TASK_W'($urandom_range(15, 1));
      if (r < 10) begin
        issue(mbq_op_t'($urandom_range(3)), BUF_W'($urandom), s, TASK_W'($urandom));
      end else if (r < 14) begin
        issue(OP_RELEASE, BUF_W'($urandom_range(NUM_BUFFERS - 1)), s, TASK_W'($urandom));
      end else begin
        r = $urandom_range(99);
        if (r < alloc_pct) begin
          issue(OP_ALLOC, BUF_W'($urandom), s, TASK_W'($urandom));
        end else if (r < alloc_pct + (100 - alloc_pct) * 35 / 100 ||
                     held_buffers.size() == 0) begin
          issue(OP_GET, BUF_W'($urandom), s, t);
        end else begin
          k = $urandom_range(held_buffers.size() - 1);
          if (r < alloc_pct + (100 - alloc_pct) * 75 / 100)
            issue(OP_POST, BUF_W'(held_buffers[k]), s, TASK_W'($urandom));
          else
            issue(OP_RELEASE, BUF_W'(held_buffers[k]), s, TASK_W'($urandom));
        end
      end
    end
  endtask

  // Result side: check each accepted beat and stall at random.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(status, buffer_index);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: too many cycles without any beat on either channel.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // Main sequence.
  initial begin
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    op       <= OP_ALLOC;
    buffer   <= '0;
    service  <= '0;
    task_req <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: error statuses with every service unrouted, then an allocation that succeeds.
    reconfigure('0);
    issue(OP_POST, 8'h00, 8'h00, 4'h0);
    issue(OP_POST, 8'hFF, 8'hFF, 4'hF);
    issue(OP_RELEASE, 8'h10, 8'h00, 4'h0);
    issue(OP_RELEASE, 8'h00, 8'h00, 4'h0);
    issue(OP_GET, 8'h00, 8'h00, 4'h0);
    issue(OP_GET, 8'h00, 8'h00, 4'hF);
    issue(OP_ALLOC, 8'hFF, 8'hFF, 4'hF);

    // Directed: each high nibble routes to the task of the same number.
    reconfigure(64'hFEDC_BA98_7654_3210);
    issue(OP_ALLOC, 8'h00, 8'h00, 4'h0);
    issue(OP_ALLOC, 8'h00, 8'h00, 4'h0);
    issue(OP_POST, 8'h00, 8'h1F, 4'h0);
    issue(OP_POST, 8'h01, 8'h10, 4'h0);
    issue(OP_GET, 8'h00, 8'h00, 4'h1);
    issue(OP_GET, 8'h00, 8'h00, 4'h1);
    issue(OP_GET, 8'h00, 8'h00, 4'h1);
    // Posting a queued buffer again closes a loop back to it; the next post walks to the bound.
    issue(OP_POST, 8'h02, 8'h20, 4'h0);
    issue(OP_POST, 8'h02, 8'h2F, 4'h0);
    issue(OP_POST, 8'h03, 8'h2A, 4'h0);
    // Posting free buffers closes a loop in the free list.
    issue(OP_POST, 8'h0F, 8'h30, 4'h0);
    issue(OP_POST, 8'h03, 8'h31, 4'h0);
    // Release walks the looped free list to its bound, then sees the double free.
    issue(OP_RELEASE, 8'h00, 8'h00, 4'h0);
    issue(OP_RELEASE, 8'h00, 8'h00, 4'h0);
    issue(OP_GET, 8'h00, 8'h00, 4'h2);
    issue(OP_ALLOC, 8'h00, 8'h00, 4'h0);
    issue(OP_RELEASE, 8'h01, 8'h00, 4'h0);
    issue(OP_GET, 8'h00, 8'h00, 4'hF);

    // Random phases under the four idle and stall mixes.
    run_phase(0, 0, random_route_table(), 30, 225);
    run_phase(72, 0, '1, 50, 225);
    run_phase(0, 72, random_route_table(), 25, 225);
    run_phase(26, 26, random_route_table(), 35, 225);

    pause_until_drained();
    repeat (IDLE_TAIL) @(posedge clk);
    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
